// ----- design/vta_pkg.sv -----
// ----------------------------------------------------------------------------
// vta_pkg
// Shared types and constants of the vertex tangent accumulator: the request
// modes and the request and response of the iterative divide / square root
// unit.
// ----------------------------------------------------------------------------
package vta_pkg;

    localparam int INDEX_W          = 10;
    localparam int MAX_VERTICES_DEF = 1024;

    // request modes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_TRI  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // iterative unit sizes
    localparam int RAD_W      = 62;           // radicand, also holds the dividend
    localparam int DVS_W      = 34;           // divisor
    localparam int QUO_W      = 51;           // quotient / root
    localparam int REM_W      = DVS_W + 1;    // partial remainder
    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    typedef enum logic {
        ITER_DIV,
        ITER_SQRT
    } iter_op_t;

    typedef struct packed {
        logic             start;
        iter_op_t         op;
        logic [RAD_W-1:0] x;
        logic [DVS_W-1:0] d;
    } iter_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] q;
    } iter_rsp_t;

endpackage

// ----- design/vertex_tangent_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// vertex_tangent_accumulator_core
// Per-vertex tangent generation: vertex load, triangle accumulation and
// Gram-Schmidt orthonormalized tangent read-out, in fixed point.
// ----------------------------------------------------------------------------
// One request at a time. A load writes the vertex and clears its sums. A
// triangle reads its three vertices, forms the determinant with the shared
// multiplier, then per tangent component forms the numerator and waits on the
// bit-serial division of a 51-bit quotient, then does a read-modify-write of
// the three sums; a triangle with a zero determinant ends after the
// determinant. A read forms the projection with the multiplier, brings the
// magnitudes into range with one-bit normalizing shifts, forms the squared
// length with the multiplier, then waits on the square root and on three
// divisions. The vertex and sum memories have one port each and need no
// clearing after reset; a vertex must be loaded before use.
// ----------------------------------------------------------------------------
module vertex_tangent_accumulator_core
    import vta_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          mode,
    input  logic signed [15:0]  pos_x,
    input  logic signed [15:0]  pos_y,
    input  logic signed [15:0]  pos_z,
    input  logic signed [15:0]  tex_u,
    input  logic signed [15:0]  tex_v,
    input  logic signed [15:0]  norm_x,
    input  logic signed [15:0]  norm_y,
    input  logic signed [15:0]  norm_z,
    input  logic [INDEX_W-1:0]  corner_a,
    input  logic [INDEX_W-1:0]  corner_b,
    input  logic [INDEX_W-1:0]  corner_c,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [INDEX_W-1:0]  vertex_index,
    output logic signed [15:0]  tangent_x,
    output logic signed [15:0]  tangent_y,
    output logic signed [15:0]  tangent_z,
    output logic                zero_length
);

    localparam int AW = $clog2(MAX_VERTICES);

    typedef struct packed {
        logic [2:0][15:0] pos;
        logic [1:0][15:0] tex;
        logic [2:0][15:0] nrm;
    } vtx_t;

    typedef logic [2:0][31:0] sum_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD,
        T_RDA, T_RDB, T_RDC, T_DLC,
        T_D0, T_D1, T_D2,
        T_N0, T_N1, T_N2, T_N3,
        T_SRD, T_SWR,
        R_RD, R_DM, R_DA, R_PM, R_PA, R_NRM,
        R_SM, R_SA, R_SQ, R_DS, R_DW, R_OUT
    } state_t;

    // control and output registers
    state_t                state_reg, state_next;
    logic [1:0]            k_reg, k_next;
    logic                  half_reg, half_next;
    logic                  out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]    out_index_reg, out_index_next;
    logic signed [15:0]    out_t_reg [3];
    logic signed [15:0]    out_t_next [3];
    logic                  out_zero_reg, out_zero_next;

    // datapath registers
    vtx_t                  in_vtx_reg, in_vtx_next;
    logic [INDEX_W-1:0]    ca_reg, ca_next, cb_reg, cb_next, cc_reg, cc_next;
    logic [2:0][15:0]      pa_reg, pa_next;
    logic [1:0][15:0]      ua_reg, ua_next;
    logic signed [16:0]    e1_reg [3];
    logic signed [16:0]    e1_next [3];
    logic signed [16:0]    e2_reg [3];
    logic signed [16:0]    e2_next [3];
    logic signed [16:0]    s1_reg, s1_next, t1_reg, t1_next;
    logic signed [16:0]    s2_reg, s2_next, t2_reg, t2_next;
    logic signed [33:0]    det_reg, det_next;
    logic                  tri_neg_reg, tri_neg_next;
    logic signed [34:0]    tan_reg [3];
    logic signed [34:0]    tan_next [3];
    logic signed [38:0]    dq_reg, dq_next;
    logic                  neg_reg [3];
    logic                  neg_next [3];
    logic [42:0]           mag_reg [3];
    logic [42:0]           mag_next [3];
    logic [30:0]           len_reg, len_next;
    logic signed [15:0]    res_reg [3];
    logic signed [15:0]    res_next [3];
    logic                  rzero_reg, rzero_next;
    logic signed [63:0]    acc_reg, acc_next;
    logic signed [56:0]    prod_reg;

    // memories
    vtx_t                  vmem [MAX_VERTICES];
    sum_t                  smem [MAX_VERTICES];
    vtx_t                  vrd_reg;
    sum_t                  srd_reg;
    logic [AW-1:0]         mem_addr;
    logic                  rd_en, v_we, s_we;
    sum_t                  s_wdata;

    // shared multiplier and iterative unit
    logic signed [17:0]    mul_a;
    logic signed [38:0]    mul_b;
    iter_req_t             iter_req;
    iter_rsp_t             iter_rsp;

    // datapath helpers
    logic                  accept_in, out_take;
    logic signed [63:0]    acc_minus, acc_plus, sq_sum, abs_diff;
    logic signed [43:0]    r_full, r_abs;
    logic [42:0]           m01, mmax;
    logic [33:0]           magc;
    logic signed [34:0]    tan_pos, tan_val;
    logic signed [15:0]    q_pos, q_val;
    logic [INDEX_W-1:0]    corner_k;

    function automatic logic idx_ok(input logic [INDEX_W-1:0] idx);
        return 32'(idx) < MAX_VERTICES;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [INDEX_W-1:0] idx);
        return AW'(idx);
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] s,
                                            input logic signed [34:0] d);
        logic signed [35:0] r;
        r = 36'($signed(s)) + 36'(d);
        if (r > 36'sh0_7FFF_FFFF)
            return 32'h7FFF_FFFF;
        else if (r < -36'sh0_8000_0000)
            return 32'h8000_0000;
        else
            return r[31:0];
    endfunction

    vta_iter u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (iter_req),
        .rsp   (iter_rsp)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign accept_in = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    assign acc_minus = acc_reg - 64'(prod_reg);
    assign acc_plus  = acc_reg + 64'(prod_reg);
    assign sq_sum    = acc_reg + (half_reg ? 64'(prod_reg) : (64'(prod_reg) <<< 15));
    assign abs_diff  = acc_minus[63] ? -acc_minus : acc_minus;

    // gram-schmidt residual of one component
    assign r_full = 44'($signed(srd_reg[k_reg])) - 44'(prod_reg >>> 12);
    assign r_abs  = r_full[43] ? -r_full : r_full;

    assign m01  = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
    assign mmax = (m01 > mag_reg[2]) ? m01 : mag_reg[2];

    // quotients past 2^33 saturate every sum anyway
    assign magc    = (|iter_rsp.q[QUO_W-1:33]) ? 34'h2_0000_0000 : iter_rsp.q[33:0];
    assign tan_pos = {1'b0, magc};
    assign tan_val = tri_neg_reg ? -tan_pos : tan_pos;

    assign q_pos = {1'b0, iter_rsp.q[14:0]};
    assign q_val = neg_reg[k_reg] ? -q_pos : q_pos;

    always_comb
    begin
        case (k_reg)
            2'd0:    corner_k = ca_reg;
            2'd1:    corner_k = cb_reg;
            default: corner_k = cc_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        half_next      = half_reg;
        out_valid_next = out_valid_reg && !out_take;
        out_index_next = out_index_reg;
        out_t_next     = out_t_reg;
        out_zero_next  = out_zero_reg;
        in_vtx_next    = in_vtx_reg;
        ca_next        = ca_reg;
        cb_next        = cb_reg;
        cc_next        = cc_reg;
        pa_next        = pa_reg;
        ua_next        = ua_reg;
        e1_next        = e1_reg;
        e2_next        = e2_reg;
        s1_next        = s1_reg;
        t1_next        = t1_reg;
        s2_next        = s2_reg;
        t2_next        = t2_reg;
        det_next       = det_reg;
        tri_neg_next   = tri_neg_reg;
        tan_next       = tan_reg;
        dq_next        = dq_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        len_next       = len_reg;
        res_next       = res_reg;
        rzero_next     = rzero_reg;
        acc_next       = acc_reg;
        mem_addr       = addr_of(ca_reg);
        rd_en          = 1'b0;
        v_we           = 1'b0;
        s_we           = 1'b0;
        s_wdata        = '0;
        mul_a          = '0;
        mul_b          = '0;
        iter_req       = '0;
        iter_req.op    = ITER_DIV;

        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    in_vtx_next.pos[0] = pos_x;
                    in_vtx_next.pos[1] = pos_y;
                    in_vtx_next.pos[2] = pos_z;
                    in_vtx_next.tex[0] = tex_u;
                    in_vtx_next.tex[1] = tex_v;
                    in_vtx_next.nrm[0] = norm_x;
                    in_vtx_next.nrm[1] = norm_y;
                    in_vtx_next.nrm[2] = norm_z;
                    ca_next            = corner_a;
                    cb_next            = corner_b;
                    cc_next            = corner_c;
                    case (mode)
                        MODE_LOAD:
                        begin
                            if (idx_ok(corner_a))
                                state_next = S_LOAD;
                        end
                        MODE_TRI:
                        begin
                            if (idx_ok(corner_a) && idx_ok(corner_b) && idx_ok(corner_c))
                                state_next = T_RDA;
                        end
                        MODE_READ:
                        begin
                            if (idx_ok(corner_a))
                                state_next = R_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_LOAD:
            begin
                v_we       = 1'b1;
                s_we       = 1'b1;
                state_next = S_IDLE;
            end

            T_RDA:
            begin
                rd_en      = 1'b1;
                state_next = T_RDB;
            end

            T_RDB:
            begin
                pa_next    = vrd_reg.pos;
                ua_next    = vrd_reg.tex;
                mem_addr   = addr_of(cb_reg);
                rd_en      = 1'b1;
                state_next = T_RDC;
            end

            T_RDC:
            begin
                for (int i = 0; i < 3; i++)
                    e1_next[i] = 17'($signed(vrd_reg.pos[i])) - 17'($signed(pa_reg[i]));
                s1_next    = 17'($signed(vrd_reg.tex[0])) - 17'($signed(ua_reg[0]));
                t1_next    = 17'($signed(vrd_reg.tex[1])) - 17'($signed(ua_reg[1]));
                mem_addr   = addr_of(cc_reg);
                rd_en      = 1'b1;
                state_next = T_DLC;
            end

            T_DLC:
            begin
                for (int i = 0; i < 3; i++)
                    e2_next[i] = 17'($signed(vrd_reg.pos[i])) - 17'($signed(pa_reg[i]));
                s2_next    = 17'($signed(vrd_reg.tex[0])) - 17'($signed(ua_reg[0]));
                t2_next    = 17'($signed(vrd_reg.tex[1])) - 17'($signed(ua_reg[1]));
                state_next = T_D0;
            end

            T_D0:
            begin
                mul_a      = 18'(s1_reg);
                mul_b      = 39'(t2_reg);
                state_next = T_D1;
            end

            T_D1:
            begin
                acc_next   = 64'(prod_reg);
                mul_a      = 18'(s2_reg);
                mul_b      = 39'(t1_reg);
                state_next = T_D2;
            end

            T_D2:
            begin
                det_next = 34'(acc_minus);
                k_next   = 2'd0;
                // degenerate uv mapping: skip the triangle
                if (acc_minus == 64'sd0)
                    state_next = S_IDLE;
                else
                    state_next = T_N0;
            end

            T_N0:
            begin
                mul_a      = 18'(t2_reg);
                mul_b      = 39'(e1_reg[k_reg]);
                state_next = T_N1;
            end

            T_N1:
            begin
                acc_next   = 64'(prod_reg);
                mul_a      = 18'(t1_reg);
                mul_b      = 39'(e2_reg[k_reg]);
                state_next = T_N2;
            end

            T_N2:
            begin
                iter_req.start = 1'b1;
                iter_req.op    = ITER_DIV;
                iter_req.x     = RAD_W'(abs_diff <<< 16);
                iter_req.d     = det_reg[33] ? 34'(-det_reg) : 34'(det_reg);
                tri_neg_next   = acc_minus[63] ^ det_reg[33];
                state_next     = T_N3;
            end

            T_N3:
            begin
                if (iter_rsp.done)
                begin
                    tan_next[k_reg] = tan_val;
                    if (k_reg == 2'd2)
                    begin
                        k_next     = 2'd0;
                        state_next = T_SRD;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = T_N0;
                    end
                end
            end

            T_SRD:
            begin
                mem_addr   = addr_of(corner_k);
                rd_en      = 1'b1;
                state_next = T_SWR;
            end

            T_SWR:
            begin
                mem_addr = addr_of(corner_k);
                s_we     = 1'b1;
                for (int i = 0; i < 3; i++)
                    s_wdata[i] = sat_add(srd_reg[i], tan_reg[i]);
                if (k_reg == 2'd2)
                    state_next = S_IDLE;
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = T_SRD;
                end
            end

            R_RD:
            begin
                rd_en      = 1'b1;
                k_next     = 2'd0;
                acc_next   = '0;
                state_next = R_DM;
            end

            R_DM:
            begin
                mul_a      = 18'($signed(vrd_reg.nrm[k_reg]));
                mul_b      = 39'($signed(srd_reg[k_reg]));
                state_next = R_DA;
            end

            R_DA:
            begin
                acc_next = acc_plus;
                if (k_reg == 2'd2)
                begin
                    dq_next    = 39'(acc_plus >>> 12);
                    k_next     = 2'd0;
                    state_next = R_PM;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = R_DM;
                end
            end

            R_PM:
            begin
                mul_a      = 18'($signed(vrd_reg.nrm[k_reg]));
                mul_b      = dq_reg;
                state_next = R_PA;
            end

            R_PA:
            begin
                neg_next[k_reg] = r_full[43];
                mag_next[k_reg] = 43'(r_abs);
                if (k_reg == 2'd2)
                    state_next = R_NRM;
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = R_PM;
                end
            end

            R_NRM:
            begin
                // bring the largest magnitude into [2^29, 2^30)
                if (mmax == '0)
                begin
                    for (int i = 0; i < 3; i++)
                        res_next[i] = '0;
                    rzero_next = 1'b1;
                    state_next = R_OUT;
                end
                else if (|mmax[42:30])
                begin
                    for (int i = 0; i < 3; i++)
                        mag_next[i] = mag_reg[i] >> 1;
                end
                else if (!mmax[29])
                begin
                    for (int i = 0; i < 3; i++)
                        mag_next[i] = mag_reg[i] << 1;
                end
                else
                begin
                    rzero_next = 1'b0;
                    k_next     = 2'd0;
                    half_next  = 1'b0;
                    acc_next   = '0;
                    state_next = R_SM;
                end
            end

            R_SM:
            begin
                // square as high half and low half partial products
                mul_a      = half_reg ? {3'b000, mag_reg[k_reg][14:0]}
                                      : {3'b000, mag_reg[k_reg][29:15]};
                mul_b      = {9'd0, mag_reg[k_reg][29:0]};
                state_next = R_SA;
            end

            R_SA:
            begin
                acc_next = sq_sum;
                if (!half_reg)
                begin
                    half_next  = 1'b1;
                    state_next = R_SM;
                end
                else if (k_reg != 2'd2)
                begin
                    half_next  = 1'b0;
                    k_next     = k_reg + 2'd1;
                    state_next = R_SM;
                end
                else
                begin
                    iter_req.start = 1'b1;
                    iter_req.op    = ITER_SQRT;
                    iter_req.x     = RAD_W'(sq_sum);
                    state_next     = R_SQ;
                end
            end

            R_SQ:
            begin
                if (iter_rsp.done)
                begin
                    len_next   = iter_rsp.q[30:0];
                    k_next     = 2'd0;
                    state_next = R_DS;
                end
            end

            R_DS:
            begin
                iter_req.start = 1'b1;
                iter_req.op    = ITER_DIV;
                iter_req.x     = RAD_W'({mag_reg[k_reg][29:0], 14'd0})
                               + RAD_W'(len_reg >> 1);
                iter_req.d     = DVS_W'(len_reg);
                state_next     = R_DW;
            end

            R_DW:
            begin
                if (iter_rsp.done)
                begin
                    res_next[k_reg] = q_val;
                    if (k_reg == 2'd2)
                        state_next = R_OUT;
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = R_DS;
                    end
                end
            end

            R_OUT:
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = ca_reg;
                    out_t_next     = res_reg;
                    out_zero_next  = rzero_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_zero_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
                out_t_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
            out_index_reg <= out_index_next;
            out_zero_reg  <= out_zero_next;
            out_t_reg     <= out_t_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_vtx_reg  <= in_vtx_next;
        ca_reg      <= ca_next;
        cb_reg      <= cb_next;
        cc_reg      <= cc_next;
        pa_reg      <= pa_next;
        ua_reg      <= ua_next;
        e1_reg      <= e1_next;
        e2_reg      <= e2_next;
        s1_reg      <= s1_next;
        t1_reg      <= t1_next;
        s2_reg      <= s2_next;
        t2_reg      <= t2_next;
        det_reg     <= det_next;
        tri_neg_reg <= tri_neg_next;
        tan_reg     <= tan_next;
        dq_reg      <= dq_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        len_reg     <= len_next;
        res_reg     <= res_next;
        rzero_reg   <= rzero_next;
        acc_reg     <= acc_next;
        prod_reg    <= mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
            vmem[mem_addr] <= in_vtx_reg;
        if (rd_en)
            vrd_reg <= vmem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
            smem[mem_addr] <= s_wdata;
        if (rd_en)
            srd_reg <= smem[mem_addr];
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = out_index_reg;
    assign tangent_x    = out_t_reg[0];
    assign tangent_y    = out_t_reg[1];
    assign tangent_z    = out_t_reg[2];
    assign zero_length  = out_zero_reg;

`ifndef SYNTHESIS
    a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !iter_rsp.busy)
        else $error("iterative unit busy while idle");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        iter_rsp.done |-> (state_reg == T_N3 || state_reg == R_SQ || state_reg == R_DW))
        else $error("iterative unit finished outside a wait state");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_length) |->
            (tangent_x == 16'sd0 && tangent_y == 16'sd0 && tangent_z == 16'sd0))
        else $error("zero-length result carries a nonzero tangent");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tangent_x <= 16'sd16384 && tangent_x >= -16'sd16384 &&
                       tangent_y <= 16'sd16384 && tangent_y >= -16'sd16384 &&
                       tangent_z <= 16'sd16384 && tangent_z >= -16'sd16384))
        else $error("tangent component out of unit range");
`endif

endmodule

// ----- design/vta_iter.sv -----
// ----------------------------------------------------------------------------
// vta_iter
// Shared shift-subtract unit: unsigned restoring division, one quotient bit
// per cycle, or floor integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module vta_iter
    import vta_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  iter_req_t req,
    output iter_rsp_t rsp
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    iter_op_t         op_reg;
    logic [RAD_W-1:0] x_reg;
    logic [DVS_W-1:0] d_reg;
    logic [REM_W-1:0] rem_reg;
    logic [QUO_W-1:0] q_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [RAD_W-1:0] x_sh;
    logic [REM_W:0]   diff;
    logic             fit;
    logic [REM_W-1:0] rem_step;
    logic [QUO_W-1:0] q_step;

    // one subtractor serves both operations
    always_comb
    begin
        if (op_reg == ITER_DIV)
        begin
            rem_sh = {rem_reg[REM_W-2:0], x_reg[QUO_W-1]};
            trial  = {1'b0, d_reg};
            x_sh   = {x_reg[RAD_W-2:0], 1'b0};
        end
        else
        begin
            rem_sh = {rem_reg[REM_W-3:0], x_reg[RAD_W-1 -: 2]};
            trial  = REM_W'({q_reg[SQRT_STEPS-1:0], 2'b01});
            x_sh   = {x_reg[RAD_W-3:0], 2'b00};
        end
        diff     = {1'b0, rem_sh} - {1'b0, trial};
        fit      = !diff[REM_W];
        rem_step = fit ? diff[REM_W-1:0] : rem_sh;
        q_step   = {q_reg[QUO_W-2:0], fit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= (req.op == ITER_DIV) ? CNT_W'(DIV_STEPS - 1)
                                                 : CNT_W'(SQRT_STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg  <= req.op;
            x_reg   <= req.x;
            d_reg   <= req.d;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            x_reg   <= x_sh;
            rem_reg <= rem_step;
            q_reg   <= q_step;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

endmodule

// ----- bench/tb_vertex_tangent_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// tb_vertex_tangent_accumulator_core
// Self-checking bench for the tangent accumulator core. A directed table of
// loads, triangles and reads is followed by random meshes. A behavioral model
// of the sums and the Gram-Schmidt read-out predicts each read response. Both
// handshake sides idle at random, with one long output stall, a drain midway and one at the end.
// ----------------------------------------------------------------------------
module tb_vertex_tangent_accumulator_core
    import vta_pkg::*;
();

    localparam int NV        = MAX_VERTICES_DEF;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1700;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] px, py, pz, tu, tv, nx, ny, nz;
        logic [9:0]         a, b, c;
    } request_t;

    typedef struct packed {
        logic [9:0]         idx;
        logic signed [15:0] tx, ty, tz;
        logic               zl;
    } tangent_t;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [1:0] mode;
    logic signed [15:0] pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z;
    logic [9:0] corner_a, corner_b, corner_c;
    logic [9:0] vertex_index;
    logic signed [15:0] tangent_x, tangent_y, tangent_z;
    logic zero_length;

    vertex_tangent_accumulator_core dut (.*);

    // predictor state
    logic signed [15:0] vpos [NV][3];
    logic signed [15:0] vtex [NV][2];
    logic signed [15:0] vnrm [NV][3];
    logic signed [31:0] vsum [NV][3];
    bit                 loaded [NV];

    tangent_t expected_tangents[$];
    int errors, mismatches, reads_seen, tris_done, degen_tris, zero_hits;
    int idle_cycles;
    bit out_idle_on, in_idle_on;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [63:0] fshr(logic signed [63:0] v, int s);
        return v >>> s;  // arithmetic shift floors
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] x);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void accumulate_triangle(int a, int b, int c);
        logic signed [63:0] e1[3], e2[3], tg[3], s1, t1, s2, t2, det, n;
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = 64'(vpos[b][k]) - 64'(vpos[a][k]);
            e2[k] = 64'(vpos[c][k]) - 64'(vpos[a][k]);
        end
        s1 = 64'(vtex[b][0]) - 64'(vtex[a][0]);
        t1 = 64'(vtex[b][1]) - 64'(vtex[a][1]);
        s2 = 64'(vtex[c][0]) - 64'(vtex[a][0]);
        t2 = 64'(vtex[c][1]) - 64'(vtex[a][1]);
        det = s1 * t2 - s2 * t1;
        if (det == 0)
        begin
            degen_tris++;
            return;
        end
        for (int k = 0; k < 3; k++)
        begin
            n = t2 * e1[k] - t1 * e2[k];
            tg[k] = (n * 64'sd65536) / det;  // truncates toward zero
        end
        for (int k = 0; k < 3; k++)
        begin
            vsum[a][k] = sat32(64'(vsum[a][k]) + tg[k]);
            vsum[b][k] = sat32(64'(vsum[b][k]) + tg[k]);
            vsum[c][k] = sat32(64'(vsum[c][k]) + tg[k]);
        end
        tris_done++;
    endfunction

    function automatic tangent_t orthonormal_tangent(int v);
        tangent_t r;
        logic signed [63:0] t[3], nn[3], rr[3], dot, dq;
        logic [63:0] mag[3], m, sq, len, q;
        dot = 0;
        for (int k = 0; k < 3; k++)
        begin
            t[k] = 64'(vsum[v][k]);
            nn[k] = 64'(vnrm[v][k]);
            dot += nn[k] * t[k];
        end
        dq = fshr(dot, 12);
        for (int k = 0; k < 3; k++)
        begin
            rr[k] = t[k] - fshr(nn[k] * dq, 12);
            mag[k] = rr[k] < 0 ? 64'(-rr[k]) : 64'(rr[k]);
        end
        r.idx = v[9:0];
        m = mag[0];
        if (mag[1] > m) m = mag[1];
        if (mag[2] > m) m = mag[2];
        if (m == 0)
        begin
            r.tx = 0; r.ty = 0; r.tz = 0; r.zl = 1;
            return r;
        end
        while (m >= (64'd1 << 30))
        begin
            for (int k = 0; k < 3; k++) mag[k] >>= 1;
            m >>= 1;
        end
        while (m < (64'd1 << 29))
        begin
            for (int k = 0; k < 3; k++) mag[k] <<= 1;
            m <<= 1;
        end
        sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = isqrt(sq);
        for (int k = 0; k < 3; k++)
        begin
            q = (mag[k] * 64'd16384 + len / 2) / len;
            if (rr[k] < 0) q = -q;
            if (k == 0) r.tx = q[15:0];
            else if (k == 1) r.ty = q[15:0];
            else r.tz = q[15:0];
        end
        r.zl = 0;
        return r;
    endfunction

    // update the model for an accepted request
    function automatic void predict(request_t q);
        int a;
        a = q.a;
        case (q.mode)
            MODE_LOAD:
            begin
                vpos[a][0] = q.px; vpos[a][1] = q.py; vpos[a][2] = q.pz;
                vtex[a][0] = q.tu; vtex[a][1] = q.tv;
                vnrm[a][0] = q.nx; vnrm[a][1] = q.ny; vnrm[a][2] = q.nz;
                for (int k = 0; k < 3; k++) vsum[a][k] = 0;
                loaded[a] = 1;
            end
            MODE_TRI: accumulate_triangle(q.a, q.b, q.c);
            MODE_READ: expected_tangents = {expected_tangents, orthonormal_tangent(a)};
            default: ;
        endcase
    endfunction

    // returns at the falling edge after acceptance with the request still
    // driven; the caller offers the next one or drops valid
    task automatic send(request_t q);
        while (in_idle_on && $urandom_range(99) < 11)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        {mode, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
         corner_a, corner_b, corner_c} <= q;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict(q);
        @(negedge clk);
    endtask

    function automatic request_t load_req(int v, int px, int py, int pz, int tu, int tv,
                                          int nx, int ny, int nz);
        request_t q;
        q = '0;
        q.mode = MODE_LOAD; q.a = v[9:0];
        q.px = px; q.py = py; q.pz = pz; q.tu = tu; q.tv = tv;
        q.nx = nx; q.ny = ny; q.nz = nz;
        return q;
    endfunction

    function automatic request_t idx_req(logic [1:0] md, int a, int b, int c);
        request_t q;
        q = '0;
        q.mode = md; q.a = a[9:0]; q.b = b[9:0]; q.c = c[9:0];
        return q;
    endfunction

    function automatic int pick_loaded();
        int v;
        do v = $urandom_range(NV - 1); while (!loaded[v]);
        return v;
    endfunction

    function automatic request_t random_load(int v);
        request_t q;
        q = load_req(v, 0, 0, 0, 0, 0, 0, 0, 0);
        {q.px, q.py, q.pz, q.tu, q.tv, q.nx, q.ny, q.nz} = {$urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(3) != 0)
        begin
            // small meshes with unit-ish normals exercise the common path
            q.px = $signed(16'($urandom_range(8191))) - 16'sd4096;
            q.py = $signed(16'($urandom_range(8191))) - 16'sd4096;
            q.pz = $signed(16'($urandom_range(8191))) - 16'sd4096;
            q.tu = $signed(16'($urandom_range(8191)));
            q.tv = $signed(16'($urandom_range(8191)));
            q.nx = $signed(16'($urandom_range(8192))) - 16'sd4096;
            q.ny = $signed(16'($urandom_range(8192))) - 16'sd4096;
            q.nz = 16'sd4096;
        end
        return q;
    endfunction

    // directed table; expected result given where obvious, else predictor only
    typedef struct {
        request_t q;
        bit       has_exp;
        tangent_t exp_t;
    } directed_row_t;

    directed_row_t directed[$];

    task automatic add_row(request_t q, bit he = 0, tangent_t e = '0);
        directed_row_t r;
        r.q = q; r.has_exp = he; r.exp_t = e;
        directed = {directed, r};
    endtask

    // response checker
    initial
    begin
        tangent_t got, want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = '{vertex_index, tangent_x, tangent_y, tangent_z, zero_length};
                reads_seen++;
                idle_cycles = 0;
                if (got.zl) zero_hits++;
                if (expected_tangents.size() == 0)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("unexpected response idx=%0d", got.idx);
                end
                else
                begin
                    want = expected_tangents.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("mismatch exp idx=%0d t=(%0d,%0d,%0d) z=%0b got idx=%0d t=(%0d,%0d,%0d) z=%0b",
                                     want.idx, want.tx, want.ty, want.tz, want.zl,
                                     got.idx, got.tx, got.ty, got.tz, got.zl);
                    end
                end
            end
        end
    end

    // watchdog on request acceptance too
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (in_valid && !in_stall) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > WDOG_MAX)
            begin
                $display("timeout with %0d responses pending", expected_tangents.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // receiver stall process
    int hold_off;
    initial
    begin
        out_stall = 0;
        hold_off = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                out_stall <= 1;
                hold_off--;
            end
            else
                out_stall <= out_idle_on && ($urandom_range(99) < 11);
        end
    end

    initial
    begin
        request_t q;
        tangent_t zt;
        int v, n;
        in_valid = 0;
        {mode, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
         corner_a, corner_b, corner_c} = '0;
        in_idle_on = 1; out_idle_on = 1;
        errors = 0; mismatches = 0; reads_seen = 0; tris_done = 0;
        degen_tris = 0; zero_hits = 0;
        for (int i = 0; i < NV; i++)
        begin
            loaded[i] = 0;
            for (int k = 0; k < 3; k++)
            begin
                vpos[i][k] = 0; vnrm[i][k] = 0; vsum[i][k] = 0;
            end
            vtex[i][0] = 0; vtex[i][1] = 0;
        end
        rst_n = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        zt = '0;
        zt.zl = 1;
        // fresh vertex reads as zero length
        add_row(load_req(0, 0, 0, 0, 0, 0, 0, 0, 4096));
        zt.idx = 0;
        add_row(idx_req(MODE_READ, 0, 0, 0), 1, zt);
        add_row(load_req(1, 4096, 0, 0, 4096, 0, 0, 0, 4096));
        add_row(load_req(2, 0, 4096, 0, 0, 4096, 0, 0, 4096));
        add_row(load_req(1023, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768));
        add_row(load_req(1022, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767));
        add_row(load_req(1021, 0, 0, 32767, 0, 0, 0, 0, 0));
        // unit square triangle gives tangent +x
        add_row(idx_req(MODE_TRI, 0, 1, 2));
        add_row(idx_req(MODE_READ, 1, 0, 0), 1, '{10'd1, 16'sd16384, 16'sd0, 16'sd0, 1'b0});
        // degenerate: repeated corner, zero determinant
        add_row(idx_req(MODE_TRI, 0, 0, 1));
        add_row(idx_req(MODE_READ, 2, 0, 0));
        // tangent parallel to normal projects to zero
        add_row(load_req(3, 0, 0, 0, 0, 0, 4096, 0, 0));
        add_row(idx_req(MODE_TRI, 3, 1, 2));
        add_row(idx_req(MODE_READ, 3, 0, 0));
        // extreme triangles saturate the sums
        add_row(idx_req(MODE_TRI, 1023, 1022, 1021));
        add_row(idx_req(MODE_TRI, 1023, 1022, 1021));
        add_row(idx_req(MODE_TRI, 1021, 1023, 1022));
        add_row(idx_req(MODE_READ, 1023, 0, 0));
        add_row(idx_req(MODE_READ, 1021, 0, 0));
        add_row(idx_req(MODE_NONE, 1023, 1023, 1023));
        add_row(idx_req(MODE_READ, 1022, 1023, 1023));
        foreach (directed[i])
        begin
            if (directed[i].has_exp)
            begin
                send(directed[i].q);
                // typed-in value replaces the predictor's copy
                if (expected_tangents.size() > 0)
                    expected_tangents[$] = directed[i].exp_t;
            end
            else
                send(directed[i].q);
        end

        // random meshes
        n = 0;
        while (n < N_RANDOM)
        begin
            int r, a, b, c;
            in_idle_on = !(n >= 400 && n < 600);
            out_idle_on = in_idle_on;
            if (n == 800) hold_off = 2500;
            if (n == 1200)
            begin
                in_valid <= 0;
                while (expected_tangents.size() != 0) @(negedge clk);
            end
            r = $urandom_range(99);
            if (r < 25)
            begin
                // a fresh random vertex load gives later triangles more loaded corners
                v = $urandom_range(NV - 1);
                send(random_load(v));
            end
            else if (r < 65)
            begin
                a = pick_loaded(); b = pick_loaded(); c = pick_loaded();
                send(idx_req(MODE_TRI, a, b, c));
            end
            else if (r < 95)
                send(idx_req(MODE_READ, pick_loaded(), $urandom, $urandom));
            else
            begin
                q = '0;
                q = {$urandom, $urandom, $urandom, $urandom};
                q.mode = MODE_NONE;
                send(q);
            end
            n++;
        end

        in_valid <= 0;
        while (expected_tangents.size() != 0) @(negedge clk);
        repeat (400) @(negedge clk);
        $display("covered %0d triangles (%0d degenerate), %0d reads, %0d zero-length",
                 tris_done, degen_tris, reads_seen, zero_hits);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
